/* hw/rtl/tcmsd_pkg.sv */
// ----------------------------------------------------------------------------
// tcmsd_pkg
// Shared types, codes, prefix text and fixed-point constants of the text
// command motor and servo driver.
// ----------------------------------------------------------------------------
package tcmsd_pkg;

	// Widths of the duty register and of the parsed number magnitude
	localparam int DUTY_BITS   = 8;
	localparam int NUMBER_BITS = 20;

	localparam logic [DUTY_BITS-1:0]   DUTY_MAX = {DUTY_BITS{1'b1}};
	localparam logic [NUMBER_BITS-1:0] MAG_MAX  = {NUMBER_BITS{1'b1}};

	// duty = |v| * DUTY_MAX / 100, done as (x >> 2) * DUTY_RECIP >> DUTY_SHIFT
	localparam int DUTY_SHIFT = DUTY_BITS + 12;
	localparam int DUTY_RECIP_INT = (1 << DUTY_SHIFT) / 25 + 1;
	localparam logic [DUTY_BITS+7:0] DUTY_RECIP = (DUTY_BITS+8)'(DUTY_RECIP_INT);

	// Speed clamp and servo scale
	localparam logic [6:0] SPEED_LIMIT = 7'd100;
	localparam logic [7:0] ANGLE_FULL  = 8'd180;
	localparam logic [7:0] PP_FULL     = 8'd200;
	localparam logic [6:0] PP_HALF     = 7'd100;

	// floor(a / 9) for a < 180 as (a * 57) >> 9
	localparam logic [5:0] DIV9_RECIP = 6'd57;
	localparam int         DIV9_SHIFT = 9;

	// floor(y / 25) for y < 6400 as (y * 10486) >> 18
	localparam logic [13:0] DIV25_RECIP = 14'd10486;
	localparam int          DIV25_SHIFT = 18;

	// Reset values
	localparam logic [7:0] SERVO_RESET = 8'd90;
	localparam logic [7:0] LOW_RESET   = 8'd35;
	localparam logic [7:0] HIGH_RESET  = 8'd145;

	// Register map (index from paddr[2])
	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	// Characters
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Prefix slots
	localparam int PFX_NUM   = 3;
	localparam int PFX_SPEED = 0;
	localparam int PFX_STOP  = 1;
	localparam int PFX_SERVO = 2;

	// Motor bridge codes
	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	typedef enum logic [1:0] {
		DONE_NONE  = 2'd0,
		DONE_SPEED = 2'd1,
		DONE_STOP  = 2'd2,
		DONE_SERVO = 2'd3
	} done_t;

	typedef enum logic [6:0] {
		PH_LEAD    = 7'b0000001,
		PH_PREFIX  = 7'b0000010,
		PH_NUM_WS  = 7'b0000100,
		PH_NUM_DIG = 7'b0001000,
		PH_NUM_END = 7'b0010000,
		PH_STOP    = 7'b0100000,
		PH_DEAD    = 7'b1000000
	} phase_t;

	// Parser stage word handed to the servo mapper
	typedef struct packed {
		logic                 valid;
		logic [1:0]           dir;
		logic                 en;
		logic [DUTY_BITS-1:0] duty;
		logic                 fire;
		logic [7:0]           pp;
		done_t                done;
	} stage_t;

	// Steering limits
	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
	} cfg_t;

	function automatic logic [3:0] pfx_len(input logic [1:0] k);
		case (k)
			2'd0:    pfx_len = 4'd8;
			2'd1:    pfx_len = 4'd6;
			2'd2:    pfx_len = 4'd10;
			default: pfx_len = 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [3:0] pos);
		logic [79:0] text;
		case (k)
			2'd0:    text = {"M_SPEED:", 16'h0000};
			2'd1:    text = {"M_STOP", 32'h0000_0000};
			2'd2:    text = {"SERVO_", "ANG:"};
			default: text = '0;
		endcase
		if (pos < 4'd10) begin
			pfx_char = text[8*(9-int'(pos)) +: 8];
		end else begin
			pfx_char = 8'd0;
		end
	endfunction

endpackage

/* hw/rtl/tcmsd_cfg.sv */
// ----------------------------------------------------------------------------
// tcmsd_cfg
// APB register file holding the steering angle limits.
// ----------------------------------------------------------------------------
module tcmsd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output tcmsd_pkg::cfg_t   cfg
);

	logic [7:0] lo_q;
	logic [7:0] hi_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write the addressed limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= tcmsd_pkg::LOW_RESET;
			hi_q <= tcmsd_pkg::HIGH_RESET;
		end else if (wr_en) begin
			if (paddr[2] == tcmsd_pkg::REG_LOW) begin
				lo_q <= pwdata[7:0];
			end else begin
				hi_q <= pwdata[7:0];
			end
		end
	end

	// Read back
	always_comb begin
		if (paddr[2] == tcmsd_pkg::REG_LOW) begin
			prdata = {24'd0, lo_q};
		end else begin
			prdata = {24'd0, hi_q};
		end
	end

	assign cfg.lo = lo_q;
	assign cfg.hi = hi_q;

endmodule

/* hw/rtl/tcmsd_parser.sv */
// ----------------------------------------------------------------------------
// tcmsd_parser
// Per-byte line parser: prefix match, number scan, and the motor commands.
// Emits one stage word per byte with the motor state after that byte.
// ----------------------------------------------------------------------------
module tcmsd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_s1,
	input  logic [7:0]          byte_s1,
	output tcmsd_pkg::stage_t   word_s2
);

	localparam int DB = tcmsd_pkg::DUTY_BITS;
	localparam int NB = tcmsd_pkg::NUMBER_BITS;

	// Line state
	tcmsd_pkg::phase_t phase_q, nxt_phase;
	logic [3:0]        pos_q, nxt_pos;
	logic [2:0]        alive_q, nxt_alive;
	logic              neg_q, nxt_neg;
	logic [NB-1:0]     mag_q, nxt_mag;

	// Motor state
	logic [1:0]        dir_q, nxt_dir;
	logic              en_q, nxt_en;
	logic [DB-1:0]     duty_q, nxt_duty;

	// Stage 2 word
	logic              valid_s2;
	logic [1:0]        dir_s2;
	logic              en_s2;
	logic [DB-1:0]     duty_s2;
	logic              fire_s2;
	logic [7:0]        pp_s2;
	tcmsd_pkg::done_t  done_s2;

	logic              fire;
	tcmsd_pkg::done_t  done;

	logic              eol, is_ws, is_dig;
	logic [3:0]        digit;
	logic [NB+3:0]     mag10;
	logic [NB-1:0]     mag_add;

	tcmsd_pkg::phase_t m_phase;
	logic [2:0]        m_alive, m_mask;
	logic [3:0]        m_pos;

	logic [6:0]        absv;
	logic [DB+6:0]     prod;
	logic [DB+4:0]     dy;
	logic [2*DB+12:0]  dprod;
	logic [DB-1:0]     speed_duty;

	logic [7:0]        mag8;
	logic [13:0]       d9prod;
	logic [7:0]        pp;

	// Classify the byte
	always_comb begin
		eol    = (byte_s1 == tcmsd_pkg::CH_LF) || (byte_s1 == tcmsd_pkg::CH_CR);
		is_ws  = byte_s1 inside {tcmsd_pkg::CH_TAB, tcmsd_pkg::CH_VT,
		                         tcmsd_pkg::CH_FF, tcmsd_pkg::CH_SP};
		is_dig = byte_s1 inside {[tcmsd_pkg::CH_ZERO:tcmsd_pkg::CH_NINE]};
		digit  = 4'(byte_s1 - tcmsd_pkg::CH_ZERO);
	end

	// Accumulate one decimal digit, saturating
	always_comb begin
		mag10 = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + (NB+4)'(digit);
		if (mag10 > (NB+4)'(tcmsd_pkg::MAG_MAX)) begin
			mag_add = tcmsd_pkg::MAG_MAX;
		end else begin
			mag_add = mag10[NB-1:0];
		end
	end

	// Match the byte against all live prefixes
	always_comb begin
		m_alive = alive_q;
		for (int k = 0; k < tcmsd_pkg::PFX_NUM; k++) begin
			if (alive_q[k] && ((pos_q >= tcmsd_pkg::pfx_len(2'(k))) ||
			    (tcmsd_pkg::pfx_char(2'(k), pos_q) != byte_s1))) begin
				m_alive[k] = 1'b0;
			end
		end
		m_pos   = pos_q + 4'd1;
		m_mask  = m_alive;
		m_phase = tcmsd_pkg::PH_PREFIX;
		if (m_alive == 3'b000) begin
			m_phase = tcmsd_pkg::PH_DEAD;
		end else if (m_alive[tcmsd_pkg::PFX_SPEED] &&
		             m_pos == tcmsd_pkg::pfx_len(2'(tcmsd_pkg::PFX_SPEED))) begin
			m_mask  = 3'b001;
			m_phase = tcmsd_pkg::PH_NUM_WS;
		end else if (m_alive[tcmsd_pkg::PFX_STOP] &&
		             m_pos == tcmsd_pkg::pfx_len(2'(tcmsd_pkg::PFX_STOP))) begin
			m_mask  = 3'b010;
			m_phase = tcmsd_pkg::PH_STOP;
		end else if (m_alive[tcmsd_pkg::PFX_SERVO] &&
		             m_pos == tcmsd_pkg::pfx_len(2'(tcmsd_pkg::PFX_SERVO))) begin
			m_mask  = 3'b100;
			m_phase = tcmsd_pkg::PH_NUM_WS;
		end
	end

	// Speed duty: clamp to 100, scale by DUTY_MAX / 100
	always_comb begin
		if (mag_q > NB'(tcmsd_pkg::SPEED_LIMIT)) begin
			absv = tcmsd_pkg::SPEED_LIMIT;
		end else begin
			absv = mag_q[6:0];
		end
		prod       = {absv, {DB{1'b0}}} - (DB+7)'(absv);
		dy         = prod[DB+6:2];
		dprod      = (2*DB+13)'(dy) * (2*DB+13)'(tcmsd_pkg::DUTY_RECIP);
		speed_duty = dprod[tcmsd_pkg::DUTY_SHIFT +: DB];
	end

	// Servo position 0..200 = trunc(a * 200 / 180) clamped, a + a / 9 below 180
	always_comb begin
		mag8   = mag_q[7:0];
		d9prod = 14'(mag8) * 14'(tcmsd_pkg::DIV9_RECIP);
		if (neg_q) begin
			pp = 8'd0;
		end else if (mag_q >= NB'(tcmsd_pkg::ANGLE_FULL)) begin
			pp = tcmsd_pkg::PP_FULL;
		end else begin
			pp = mag8 + 8'(d9prod[13:tcmsd_pkg::DIV9_SHIFT]);
		end
	end

	// Next state for one byte
	always_comb begin
		nxt_phase = phase_q;
		nxt_pos   = pos_q;
		nxt_alive = alive_q;
		nxt_neg   = neg_q;
		nxt_mag   = mag_q;
		nxt_dir   = dir_q;
		nxt_en    = en_q;
		nxt_duty  = duty_q;
		fire      = 1'b0;
		done      = tcmsd_pkg::DONE_NONE;
		if (eol) begin
			if (phase_q == tcmsd_pkg::PH_NUM_WS || phase_q == tcmsd_pkg::PH_NUM_DIG ||
			    phase_q == tcmsd_pkg::PH_NUM_END) begin
				if (alive_q[tcmsd_pkg::PFX_SPEED]) begin
					done   = tcmsd_pkg::DONE_SPEED;
					nxt_en = 1'b1;
					if (mag_q == '0) begin
						nxt_duty = '0;
						nxt_en   = 1'b0;
					end else begin
						nxt_dir  = neg_q ? tcmsd_pkg::DIR_REV : tcmsd_pkg::DIR_FWD;
						nxt_duty = speed_duty;
					end
				end else begin
					done = tcmsd_pkg::DONE_SERVO;
					fire = 1'b1;
				end
			end else if (phase_q == tcmsd_pkg::PH_STOP) begin
				done     = tcmsd_pkg::DONE_STOP;
				nxt_duty = '0;
				nxt_en   = 1'b0;
			end
			// Clear the line
			nxt_phase = tcmsd_pkg::PH_LEAD;
			nxt_pos   = 4'd0;
			nxt_alive = 3'b111;
			nxt_neg   = 1'b0;
			nxt_mag   = '0;
		end else begin
			case (phase_q)
				tcmsd_pkg::PH_LEAD, tcmsd_pkg::PH_PREFIX: begin
					if (!(phase_q == tcmsd_pkg::PH_LEAD && is_ws)) begin
						nxt_phase = m_phase;
						nxt_pos   = m_pos;
						nxt_alive = m_mask;
					end
				end
				tcmsd_pkg::PH_NUM_WS: begin
					if (!is_ws) begin
						if (byte_s1 == tcmsd_pkg::CH_MINUS) begin
							nxt_neg   = 1'b1;
							nxt_phase = tcmsd_pkg::PH_NUM_DIG;
						end else if (byte_s1 == tcmsd_pkg::CH_PLUS) begin
							nxt_phase = tcmsd_pkg::PH_NUM_DIG;
						end else if (is_dig) begin
							nxt_mag   = mag_add;
							nxt_phase = tcmsd_pkg::PH_NUM_DIG;
						end else begin
							nxt_phase = tcmsd_pkg::PH_NUM_END;
						end
					end
				end
				tcmsd_pkg::PH_NUM_DIG: begin
					if (is_dig) begin
						nxt_mag = mag_add;
					end else begin
						nxt_phase = tcmsd_pkg::PH_NUM_END;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance line and motor state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tcmsd_pkg::PH_LEAD;
			pos_q   <= 4'd0;
			alive_q <= 3'b111;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			dir_q   <= tcmsd_pkg::DIR_OFF;
			en_q    <= 1'b1;
			duty_q  <= '0;
		end else if (adv && valid_s1) begin
			phase_q <= nxt_phase;
			pos_q   <= nxt_pos;
			alive_q <= nxt_alive;
			neg_q   <= nxt_neg;
			mag_q   <= nxt_mag;
			dir_q   <= nxt_dir;
			en_q    <= nxt_en;
			duty_q  <= nxt_duty;
		end
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s2  <= nxt_dir;
			en_s2   <= nxt_en;
			duty_s2 <= nxt_duty;
			fire_s2 <= fire & valid_s1;
			pp_s2   <= pp;
			done_s2 <= done;
		end
	end

	assign word_s2.valid = valid_s2;
	assign word_s2.dir   = dir_s2;
	assign word_s2.en    = en_s2;
	assign word_s2.duty  = duty_s2;
	assign word_s2.fire  = fire_s2;
	assign word_s2.pp    = pp_s2;
	assign word_s2.done  = done_s2;

	// A disabled driver always carries zero duty
	a_idle_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		!en_q |-> (duty_q == '0))
		else $error("driver disabled with nonzero duty");

	// A stop word carries a stopped motor
	a_stop_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2 == tcmsd_pkg::DONE_STOP) |-> (!en_s2 && duty_s2 == '0))
		else $error("stop word with running motor");

endmodule

/* hw/rtl/tcmsd_servo_map.sv */
// ----------------------------------------------------------------------------
// tcmsd_servo_map
// Maps the servo position to a limited angle over two stages and holds the
// result register and the servo angle.
// ----------------------------------------------------------------------------
module tcmsd_servo_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  tcmsd_pkg::stage_t            word_s2,
	input  tcmsd_pkg::cfg_t              cfg,
	output logic                         valid_s4,
	output logic [1:0]                   dir_s4,
	output logic                         en_s4,
	output logic [tcmsd_pkg::DUTY_BITS-1:0] duty_s4,
	output logic                         written_s4,
	output tcmsd_pkg::done_t             done_s4,
	output logic [7:0]                   servo_q
);

	localparam int DB = tcmsd_pkg::DUTY_BITS;

	// Stage 3
	logic                valid_s3;
	logic [1:0]          dir_s3;
	logic                en_s3;
	logic [DB-1:0]       duty_s3;
	logic                fire_s3;
	logic signed [17:0]  q_s3;
	tcmsd_pkg::done_t    done_s3;

	logic signed [8:0]   span;
	logic                qneg;
	logic [16:0]         qa;
	logic [16:0]         qx;
	logic [27:0]         rprod;
	logic [7:0]          r;
	logic signed [10:0]  ang;
	logic [7:0]          ang_lim;
	logic                write;

	assign span = $signed({1'b0, cfg.hi}) - $signed({1'b0, cfg.lo});

	// Stage 3 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= word_s2.valid;
		end
	end

	// Stage 3: scale the position by the limit span
	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s3  <= word_s2.dir;
			en_s3   <= word_s2.en;
			duty_s3 <= word_s2.duty;
			fire_s3 <= word_s2.fire;
			q_s3    <= $signed({1'b0, word_s2.pp}) * span;
			done_s3 <= word_s2.done;
		end
	end

	// Divide by 200 rounding half away from zero, offset and clamp
	always_comb begin
		qneg  = q_s3[17];
		qa    = qneg ? 17'(-q_s3) : q_s3[16:0];
		qx    = qa + 17'(tcmsd_pkg::PP_HALF);
		rprod = 28'(qx[16:3]) * 28'(tcmsd_pkg::DIV25_RECIP);
		r     = rprod[tcmsd_pkg::DIV25_SHIFT +: 8];
		if (qneg) begin
			ang = $signed({3'b000, cfg.lo}) - $signed({3'b000, r});
		end else begin
			ang = $signed({3'b000, cfg.lo}) + $signed({3'b000, r});
		end
		ang_lim = ang[7:0];
		if (ang < $signed({3'b000, cfg.lo})) begin
			ang_lim = cfg.lo;
		end
		if (ang_lim > cfg.hi) begin
			ang_lim = cfg.hi;
		end
		write = valid_s3 && fire_s3 && (ang_lim != servo_q);
	end

	// Result register valid and servo angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			servo_q  <= tcmsd_pkg::SERVO_RESET;
		end else if (adv) begin
			valid_s4 <= valid_s3;
			if (write) begin
				servo_q <= ang_lim;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s4     <= dir_s3;
			en_s4      <= en_s3;
			duty_s4    <= duty_s3;
			written_s4 <= write;
			done_s4    <= done_s3;
		end
	end

	// A servo write is only reported on a servo command
	a_written_servo: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && written_s4) |-> (done_s4 == tcmsd_pkg::DONE_SERVO))
		else $error("servo write outside servo command");

	// The angle moves only together with a reported write
	a_angle_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(servo_q != $past(servo_q)) |-> (valid_s4 && written_s4))
		else $error("servo angle changed without a write");

	// A freshly loaded write really changed the angle
	a_write_changes: assert property (@(posedge clk) disable iff (!arst_n)
		($past(adv) && valid_s4 && written_s4) |-> (servo_q != $past(servo_q)))
		else $error("servo write without change");

endmodule

/* hw/rtl/text_command_motor_servo_driver.sv */
// ----------------------------------------------------------------------------
// text_command_motor_servo_driver
// Parses text command lines byte by byte and drives the motor bridge, the
// PWM duty and the steering servo angle.
//
//   port group   handshake            contents
//   rx           rx_valid / rx_ready   rx_byte, one character per word
//   res          res_valid / res_ready motor and servo state after each byte
//   apb          psel/penable/pready   servo_low_limit at 0, servo_high_limit at 4
//
// One byte enters per cycle while the pipeline advances; its result word passes
// through the input register, parser stage, span multiply stage and result
// register. The whole pipeline advances together and holds while res_valid
// is high and res_ready is low; rx_ready follows that same advance.
// Reset loads the limits 35 and 145, servo 90, driver enabled, zero duty.
// ----------------------------------------------------------------------------
module text_command_motor_servo_driver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  motor_direction,
	output logic        motor_enabled,
	output logic [7:0]  motor_duty,
	output logic [7:0]  servo_angle,
	output logic        servo_written,
	output logic [1:0]  command_done
);

	localparam int DB = tcmsd_pkg::DUTY_BITS;

	logic                 adv;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	tcmsd_pkg::stage_t    word_s2;
	tcmsd_pkg::cfg_t      cfg;
	logic                 valid_s4;
	logic [1:0]           dir_s4;
	logic                 en_s4;
	logic [DB-1:0]        duty_s4;
	logic                 written_s4;
	tcmsd_pkg::done_t     done_s4;
	logic [7:0]           servo_q;
	logic [DB+7:0]        duty_ext;

	// Advance whenever the result register is free or being taken
	assign adv      = !valid_s4 || res_ready;
	assign rx_ready = adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s1 <= rx_byte;
		end
	end

	tcmsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcmsd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.word_s2  (word_s2)
	);

	tcmsd_servo_map u_servo (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.word_s2    (word_s2),
		.cfg        (cfg),
		.valid_s4   (valid_s4),
		.dir_s4     (dir_s4),
		.en_s4      (en_s4),
		.duty_s4    (duty_s4),
		.written_s4 (written_s4),
		.done_s4    (done_s4),
		.servo_q    (servo_q)
	);

	// Drive the result word
	assign duty_ext        = {8'd0, duty_s4};
	assign res_valid       = valid_s4;
	assign motor_direction = dir_s4;
	assign motor_enabled   = en_s4;
	assign motor_duty      = duty_ext[7:0];
	assign servo_angle     = servo_q;
	assign servo_written   = written_s4;
	assign command_done    = done_s4;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the text command motor and servo driver: command lines are fed one
// byte per word, every result word is checked against a software parser of the
// same commands or a typed expectation, and limits are reprogrammed per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import tcmsd_pkg::*;

	localparam int RAND_BYTES  = 560;
	localparam int RAND_PHASES = 7;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SHOWN_FAILS = 10;

	localparam logic [2:0] LOW_LIMIT_ADDR  = {REG_LOW, 2'b00};
	localparam logic [2:0] HIGH_LIMIT_ADDR = {REG_HIGH, 2'b00};

	// One result word as the block reports it
	typedef struct packed {
		logic [1:0] dir;
		logic       en;
		logic [7:0] duty;
		logic [7:0] angle;
		logic       written;
		done_t      done;
	} drive_report_t;

	typedef struct {
		string         text;
		bit            typed;
		drive_report_t want;
	} line_case_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  motor_direction;
	logic        motor_enabled;
	logic [7:0]  motor_duty;
	logic [7:0]  servo_angle;
	logic        servo_written;
	logic [1:0]  command_done;

	text_command_motor_servo_driver i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.rx_valid        (rx_valid),
		.rx_ready        (rx_ready),
		.rx_byte         (rx_byte),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.motor_direction (motor_direction),
		.motor_enabled   (motor_enabled),
		.motor_duty      (motor_duty),
		.servo_angle     (servo_angle),
		.servo_written   (servo_written),
		.command_done    (command_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Parser mirror: line state, motor state and steering limits
	string                  cmd_text [3] = '{"M_SPEED:", "M_STOP", {"SERVO_", "ANG:"}};
	phase_t                 parse_phase = PH_LEAD;
	logic [3:0]             match_pos = '0;
	logic [2:0]             live_cmds = 3'b111;
	logic                   num_neg = 1'b0;
	logic [NUMBER_BITS-1:0] num_mag = '0;
	logic [1:0]             bridge_q = DIR_OFF;
	logic                   standby_q = 1'b1;
	logic [DUTY_BITS-1:0]   duty_q = '0;
	logic [7:0]             steer_q = SERVO_RESET;
	logic [7:0]             steer_lo = LOW_RESET;
	logic [7:0]             steer_hi = HIGH_RESET;

	drive_report_t pending_reports [$];
	line_case_t    line_cases [$];
	logic [7:0]    line_buf [$];
	drive_report_t seen_report;
	drive_report_t due_report;
	int            fail_count = 0;
	int            sent_bytes = 0;
	bit            hold_req = 1'b0;
	bit            no_idle = 1'b0;

	function automatic drive_report_t report_of(input logic [1:0] d, input logic e,
		input logic [7:0] du, input logic [7:0] an, input logic w, input done_t dn);
		report_of = {d, e, du, an, w, dn};
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SP;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void reset_line();
		parse_phase = PH_LEAD;
		match_pos = '0;
		live_cmds = 3'b111;
		num_neg = 1'b0;
		num_mag = '0;
	endfunction

	// Accumulate one decimal digit, saturating the magnitude
	function automatic void push_digit(input logic [7:0] c);
		logic [63:0] m;
		m = 64'(num_mag) * 64'd10 + 64'(c - CH_ZERO);
		num_mag = (m > 64'(MAG_MAX)) ? MAG_MAX : m[NUMBER_BITS-1:0];
	endfunction

	// Narrow the surviving prefixes by one character
	function automatic void match_char(input logic [7:0] c);
		logic [2:0] live;
		int         pos;
		int         k;
		pos = match_pos;
		live = live_cmds;
		for (k = 0; k < PFX_NUM; k++) begin
			if (live[k] && (pos >= cmd_text[k].len() || cmd_text[k][pos] != c)) begin
				live[k] = 1'b0;
			end
		end
		pos++;
		match_pos = 4'(pos);
		live_cmds = live;
		if (live == 3'b000) begin
			parse_phase = PH_DEAD;
			return;
		end
		for (k = 0; k < PFX_NUM; k++) begin
			if (live[k] && pos == cmd_text[k].len()) begin
				live_cmds = 3'b001 << k;
				parse_phase = (k == PFX_STOP) ? PH_STOP : PH_NUM_WS;
				return;
			end
		end
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		case (parse_phase)
			PH_LEAD: begin
				if (!is_blank(c)) begin
					parse_phase = PH_PREFIX;
					match_char(c);
				end
			end
			PH_PREFIX: match_char(c);
			PH_NUM_WS: begin
				if (!is_blank(c)) begin
					if (c == CH_MINUS) begin
						num_neg = 1'b1;
						parse_phase = PH_NUM_DIG;
					end else if (c == CH_PLUS) begin
						parse_phase = PH_NUM_DIG;
					end else if (is_digit(c)) begin
						push_digit(c);
						parse_phase = PH_NUM_DIG;
					end else begin
						parse_phase = PH_NUM_END;
					end
				end
			end
			PH_NUM_DIG: begin
				if (is_digit(c)) begin
					push_digit(c);
				end else begin
					parse_phase = PH_NUM_END;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void apply_speed(input longint v);
		longint mag;
		if (v > 100) v = 100;
		if (v < -100) v = -100;
		standby_q = 1'b1;
		if (v == 0) begin
			duty_q = '0;
			standby_q = 1'b0;
			return;
		end
		bridge_q = (v > 0) ? DIR_FWD : DIR_REV;
		mag = (v > 0) ? v : -v;
		duty_q = DUTY_BITS'((mag * longint'(DUTY_MAX)) / 100);
	endfunction

	// Map 0..180 onto the steering span; true when the angle moves
	function automatic bit apply_steer(input longint a);
		longint lo;
		longint hi;
		longint p;
		longint q;
		longint r;
		longint ang;
		lo = longint'(steer_lo);
		hi = longint'(steer_hi);
		p = (a * 200) / 180 - 100;
		if (p < -100) p = -100;
		if (p > 100) p = 100;
		q = (p + 100) * (hi - lo);
		r = (q >= 0) ? (q + 100) / 200 : -((-q + 100) / 200);
		ang = lo + r;
		if (ang < lo) ang = lo;
		if (ang > hi) ang = hi;
		if (ang[7:0] == steer_q) return 1'b0;
		steer_q = ang[7:0];
		return 1'b1;
	endfunction

	// Advance the mirror by one byte and return the word it should produce
	function automatic drive_report_t take_byte(input logic [7:0] c);
		drive_report_t r;
		longint        v;
		r.written = 1'b0;
		r.done = DONE_NONE;
		if (c == CH_LF || c == CH_CR) begin
			if (parse_phase == PH_NUM_WS || parse_phase == PH_NUM_DIG ||
				parse_phase == PH_NUM_END) begin
				v = longint'(num_mag);
				if (num_neg) v = -v;
				if (live_cmds[PFX_SPEED]) begin
					apply_speed(v);
					r.done = DONE_SPEED;
				end else begin
					r.written = apply_steer(v);
					r.done = DONE_SERVO;
				end
			end else if (parse_phase == PH_STOP) begin
				duty_q = '0;
				standby_q = 1'b0;
				r.done = DONE_STOP;
			end
			reset_line();
		end else begin
			parse_char(c);
		end
		r.dir = bridge_q;
		r.en = standby_q;
		r.duty = duty_q[7:0];
		r.angle = steer_q;
		return r;
	endfunction

	function automatic string show(input drive_report_t r);
		return $sformatf("dir=%0d en=%0d duty=%0d angle=%0d wr=%0d done=%0d",
			r.dir, r.en, r.duty, r.angle, r.written, r.done);
	endfunction

	function automatic void note_failure(input string what, input drive_report_t want,
		input drive_report_t got);
		fail_count++;
		if (fail_count <= SHOWN_FAILS) begin
			$display("%s: expected %s, got %s", what, show(want), show(got));
		end
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_case(input string text, input bit typed,
		input drive_report_t want);
		line_case_t lc;
		lc.text = text;
		lc.typed = typed;
		lc.want = want;
		line_cases.push_back(lc);
	endfunction

	function automatic void add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0:       return CH_TAB;
			1:       return CH_VT;
			2:       return CH_FF;
			default: return CH_SP;
		endcase
	endfunction

	// Argument text: optional blanks, optional sign, mostly digits, optional junk
	function automatic void add_number(input int k);
		int sel;
		int val;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
		end
		sel = $urandom_range(0, 9);
		if (sel < 3) line_buf.push_back(CH_MINUS);
		else if (sel == 3) line_buf.push_back(CH_PLUS);
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			// no digits at all
		end else if (sel == 1) begin
			add_text($sformatf("%0d%0d", $urandom_range(0, 9999999), $urandom_range(0, 99)));
		end else begin
			val = (k == PFX_SPEED) ? $urandom_range(0, 120) : $urandom_range(0, 200);
			add_text($sformatf("%0d", val));
		end
		if ($urandom_range(0, 4) == 0) line_buf.push_back(8'($urandom_range(33, 126)));
	endfunction

	// Build one random line: mostly commands, some broken prefixes, some noise
	function automatic void make_line();
		int kind;
		int k;
		int cut;
		line_buf = {};
		kind = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
		end
		if (kind < 80) begin
			k = (kind < 35) ? PFX_SPEED : (kind < 50) ? PFX_STOP : PFX_SERVO;
			add_text(cmd_text[k]);
			if (k != PFX_STOP) begin
				add_number(k);
			end else if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(32, 126)));
			end
		end else if (kind < 90) begin
			k = $urandom_range(0, PFX_NUM - 1);
			cut = $urandom_range(1, cmd_text[k].len() - 1);
			add_text(cmd_text[k].substr(0, cut - 1));
			if ($urandom_range(0, 1) == 1) line_buf.push_back(8'($urandom_range(33, 126)));
		end else begin
			repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom));
		end
		line_buf.push_back(($urandom_range(0, 1) == 1) ? CH_LF : CH_CR);
	endfunction

	// Offer one word on rx, wait for it to be taken, then queue its result
	task automatic send_byte(input logic [7:0] b, input bit typed, input drive_report_t want);
		drive_report_t r;
		int            g;
		g = idle_gap();
		if (g > 0) begin
			rx_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		r = take_byte(b);
		pending_reports.push_back(typed ? want : r);
		sent_bytes++;
	endtask

	task automatic send_line(input string s, input bit typed, input drive_report_t want);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_byte(s[i], typed && i == s.len() - 1, want);
		end
	endtask

	// Drop valid and wait until every queued word has come back
	task automatic settle();
		rx_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == LOW_LIMIT_ADDR) steer_lo = val;
		else steer_hi = val;
		@(posedge clk);
	endtask

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			seen_report = {motor_direction, motor_enabled, motor_duty, servo_angle,
				servo_written, done_t'(command_done)};
			if (pending_reports.size() == 0) begin
				note_failure("unexpected result word", '0, seen_report);
			end else begin
				due_report = pending_reports.pop_front();
				if (seen_report != due_report) begin
					note_failure("result mismatch", due_report, seen_report);
				end
			end
		end
	end

	// Receiver: runs of ready, random gaps, and one long hold when asked
	initial begin
		int g;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			g = idle_gap();
			if (g > 0) begin
				res_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	initial begin
		int still;
		still = 0;
		wait (arst_n);
		while (still < STALL_LIMIT) begin
			@(posedge clk);
			if ((rx_valid && rx_ready) || (res_valid && res_ready) || psel) still = 0;
			else still++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int         ph;
		int         goal;
		logic [7:0] lo;
		logic [7:0] hi;

		// Directed lines, default limits 35..145
		add_case("\n", 1, report_of(DIR_OFF, 1'b1, 8'd0, 8'd90, 1'b0, DONE_NONE));
		add_case("M_SPEED:100\n", 1, report_of(DIR_FWD, 1'b1, 8'd255, 8'd90, 1'b0, DONE_SPEED));
		add_case("M_SPEED:-100\r", 1, report_of(DIR_REV, 1'b1, 8'd255, 8'd90, 1'b0, DONE_SPEED));
		add_case(" \tM_SPEED: +5000000\n", 1,
			report_of(DIR_FWD, 1'b1, 8'd255, 8'd90, 1'b0, DONE_SPEED));
		add_case("M_SPEED:-37\n", 0, '0);
		add_case("M_SPEED:0\n", 1, report_of(DIR_REV, 1'b0, 8'd0, 8'd90, 1'b0, DONE_SPEED));
		add_case("M_SPEED:42\n", 0, '0);
		add_case("M_STOP and more\r", 1,
			report_of(DIR_FWD, 1'b0, 8'd0, 8'd90, 1'b0, DONE_STOP));
		add_case({cmd_text[PFX_SERVO], "180\n"}, 1,
			report_of(DIR_FWD, 1'b0, 8'd0, 8'd145, 1'b1, DONE_SERVO));
		add_case({cmd_text[PFX_SERVO], "0\n"}, 1,
			report_of(DIR_FWD, 1'b0, 8'd0, 8'd35, 1'b1, DONE_SERVO));
		add_case({cmd_text[PFX_SERVO], "-999999999\n"}, 1,
			report_of(DIR_FWD, 1'b0, 8'd0, 8'd35, 1'b0, DONE_SERVO));
		add_case({cmd_text[PFX_SERVO], "91\n"}, 0, '0);
		add_case({cmd_text[PFX_SERVO], "  +45xyz\n"}, 0, '0);
		add_case("M_SPE\n", 0, '0);
		add_case("M_SPEED\n", 0, '0);
		add_case("XM_STOP\n", 0, '0);
		add_case("M_SPEED:abc\n", 0, '0);
		add_case("M_SPEED:-\n", 0, '0);
		add_case("M_SPEED:12 34\n", 0, '0);
		add_case({cmd_text[PFX_SERVO], "\n"}, 0, '0);
		add_case("\tM_STOP\n", 0, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (line_cases[i]) send_line(line_cases[i].text, line_cases[i].typed,
			line_cases[i].want);
		// NUL and all-ones bytes are ordinary characters
		send_byte(8'h00, 1'b0, '0);
		send_byte(8'hFF, 1'b0, '0);
		send_byte(CH_CR, 1'b0, '0);

		// Random lines under several limit settings
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0:       begin lo = 8'd0;   hi = 8'd180; end
				1:       begin lo = 8'd150; hi = 8'd20;  end
				2:       begin lo = 8'd0;   hi = 8'd0;   end
				3:       begin lo = 8'd180; hi = 8'd180; end
				4:       begin lo = LOW_RESET; hi = HIGH_RESET; end
				default: begin
					lo = 8'($urandom_range(0, 180));
					hi = 8'($urandom_range(0, 180));
				end
			endcase
			settle();
			write_reg(LOW_LIMIT_ADDR, lo);
			write_reg(HIGH_LIMIT_ADDR, hi);
			if (ph == 1) hold_req = 1'b1;
			no_idle = (ph == 3);
			goal = sent_bytes + RAND_BYTES / RAND_PHASES;
			while (sent_bytes < goal) begin
				make_line();
				foreach (line_buf[i]) send_byte(line_buf[i], 1'b0, '0);
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/tcmsd_pkg.sv
hw/rtl/tcmsd_cfg.sv
hw/rtl/tcmsd_parser.sv
hw/rtl/tcmsd_servo_map.sv
hw/rtl/text_command_motor_servo_driver.sv
test/tb.sv
